@@ rtl/core/asc_pkg.sv @@
// Package: shared types, constants and the axis scaling function for the accelerometer step counter.
package asc_pkg;

  localparam int unsigned CodeWidth  = 12;
  localparam int unsigned AccelWidth = 11;
  localparam int unsigned MagWidth   = 21;
  localparam int unsigned LimitWidth = 22;
  localparam int unsigned StepWidth  = 16;
  localparam int unsigned SqWidth    = 20;
  localparam logic [CodeWidth:0] MidCode = 13'h800;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DETECT,
    ST_HOLD
  } state_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  // Scale one axis: (2048 - code) * 1000 / 819 / 4, truncated toward zero.
  function automatic logic signed [AccelWidth-1:0] scale_axis(
    input logic [7:0] hi,
    input logic [7:0] lo
  );
    logic [CodeWidth-1:0] code;
    logic signed [CodeWidth:0] diff;
    logic [CodeWidth-1:0] mag_in;
    logic [31:0] prod;
    logic [AccelWidth-1:0] res;
    code = {hi, lo[7:4]};
    diff = $signed(MidCode) - $signed({1'b0, code});
    mag_in = diff[CodeWidth] ? CodeWidth'(-diff) : diff[CodeWidth-1:0];
    // Both truncating divisions fold into one: floor(m * 250 / 819), taken
    // by a reciprocal multiply that is exact for every magnitude up to 2048.
    prod = 32'(mag_in) * 32'd640157;
    res = AccelWidth'(prod >> 21);
    scale_axis = diff[CodeWidth] ? -$signed(res) : $signed(res);
  endfunction

endpackage

@@ rtl/core/asc_square.sv @@
// Bit-serial squarer: shift-and-add of an axis magnitude by itself.
module asc_square import asc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [AccelWidth-1:0] value,
  output logic                         done,
  output logic [SqWidth-1:0]           square
);

  logic [AccelWidth-2:0] mcand;
  logic [AccelWidth-2:0] mplier;
  logic [SqWidth-1:0]    acc;
  logic [SqWidth-1:0]    addend;
  logic [3:0]            count;
  logic                  busy;

  assign addend = SqWidth'(mcand) << count;
  assign square = acc;

  // Advance one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 4'd1;
        if (count == 4'(AccelWidth-2)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= value[AccelWidth-1] ? (AccelWidth-1)'(-value) : value[AccelWidth-2:0];
      mplier <= value[AccelWidth-1] ? (AccelWidth-1)'(-value) : value[AccelWidth-2:0];
      acc    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + addend;
      end
      mplier <= mplier >> 1;
    end
  end

endmodule

@@ rtl/core/accel_step_counter_top.sv @@
// Top level: accelerometer scaling, step detection and free-fall flag.
//  channel | direction | handshake      | payload
//  in      | input     | valid / stall  | operation, x/y/z high and low bytes
//  out     | output    | valid / stall  | x/y/z_accel, magnitude_sq, steps, flags
//  cfg     | input     | valid / ready  | free_fall_limit
// A sample's result becomes valid after three squarings that share one
// bit-serial squarer (each: start, ten shift-add steps, done), followed by
// a detect state. A clear item goes straight to the result hold state.
// rst is synchronous, clears control state and loads the limit with 2048.
// The result register holds while out_stall is high; the next item
// is taken once the previous result has left.
module accel_step_counter_top import asc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [7:0]                   x_high,
  input  logic [7:0]                   x_low,
  input  logic [7:0]                   y_high,
  input  logic [7:0]                   y_low,
  input  logic [7:0]                   z_high,
  input  logic [7:0]                   z_low,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [AccelWidth-1:0] x_accel,
  output logic signed [AccelWidth-1:0] y_accel,
  output logic signed [AccelWidth-1:0] z_accel,
  output logic [MagWidth-1:0]          magnitude_sq,
  output logic [StepWidth-1:0]         steps,
  output logic                         step_seen,
  output logic                         free_fall,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [LimitWidth-1:0]        cfg_data
);

  state_t state, state_next;
  logic [LimitWidth-1:0] free_fall_limit;
  logic                  armed;
  logic [LimitWidth-1:0] step_limit;
  logic [StepWidth-1:0]  step_total;
  logic [1:0]            axis;
  logic                  sq_start, sq_done;
  logic [SqWidth-1:0]    sq_out;
  logic signed [AccelWidth-1:0] sq_in;
  logic [MagWidth-1:0]   mag;
  logic [LimitWidth-1:0] mag_half, mag_dbl;
  logic                  accept;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign mag_half  = LimitWidth'(mag >> 1);
  assign mag_dbl   = {mag, 1'b0};

  // Register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_fall_limit <= LimitWidth'(2048);
    end else if (cfg_valid && cfg_ready) begin
      free_fall_limit <= cfg_data;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = (op_t'(operation) == OP_CLEAR) ? ST_HOLD : ST_SQUARE;
      ST_SQUARE: if (sq_done && axis == 2'd2) state_next = ST_DETECT;
      ST_DETECT: state_next = ST_HOLD;
      ST_HOLD:   if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_HOLD);
  end

  always_comb begin
    case (axis)
      2'd0:    sq_in = x_accel;
      2'd1:    sq_in = y_accel;
      default: sq_in = z_accel;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    sq_start <= 1'b0;
    if (accept && op_t'(operation) == OP_SAMPLE) begin
      sq_start <= 1'b1;
    end else if (state == ST_SQUARE && sq_done && axis != 2'd2) begin
      sq_start <= 1'b1;
    end
  end

  asc_square u_square (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .value  (sq_in),
    .done   (sq_done),
    .square (sq_out)
  );

  // Capture or clear, accumulate squares and update the detector.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b0;
      step_limit <= '0;
      step_total <= '0;
    end else if (accept) begin
      axis <= 2'd0;
      mag  <= '0;
      step_seen <= 1'b0;
      free_fall <= 1'b0;
      if (op_t'(operation) == OP_CLEAR) begin
        armed      <= 1'b0;
        step_limit <= '0;
        step_total <= '0;
        x_accel    <= '0;
        y_accel    <= '0;
        z_accel    <= '0;
      end else begin
        x_accel <= scale_axis(x_high, x_low);
        y_accel <= scale_axis(y_high, y_low);
        z_accel <= scale_axis(z_high, z_low);
      end
    end else if (state == ST_SQUARE && sq_done) begin
      mag  <= mag + MagWidth'(sq_out);
      axis <= axis + 2'd1;
    end else if (state == ST_DETECT) begin
      free_fall <= (LimitWidth'(mag) < free_fall_limit);
      if (armed) begin
        if (LimitWidth'(mag) > step_limit) begin
          armed      <= 1'b0;
          step_limit <= mag_half;
          step_total <= step_total + StepWidth'(1);
          step_seen  <= 1'b1;
        end else if (step_limit > mag_dbl) begin
          step_limit <= mag_dbl;
        end
      end else begin
        if (LimitWidth'(mag) < step_limit) begin
          armed      <= 1'b1;
          step_limit <= mag_dbl;
        end else if (step_limit < mag_half) begin
          step_limit <= mag_half;
        end
      end
    end
  end

  assign magnitude_sq = mag;
  assign steps        = step_total;

endmodule
